// File: sv/cli_pkg.sv
package cli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 9;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = COUNT_W'(2);

  localparam logic [1:0] REGION_INSIDE = 2'd0;
  localparam logic [1:0] REGION_LOW    = 2'd1;
  localparam logic [1:0] REGION_HIGH   = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               point_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               region;
  } result_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SEARCH,
    ST_PROBE,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } back_state_t;

endpackage

// File: sv/cli_front.sv
module cli_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cli_pkg::item_t item,
  output logic           busy,
  output logic           cmd_valid,
  output cli_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);
  import cli_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t               slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     fill;
  cmd_t               incoming;
  logic               push;
  logic               pop;

  always_comb begin
    incoming.index = item.point_index[IDX_W-1:0];
    incoming.y     = item.point_y;
    if (item.kind) begin
      incoming.op = OP_QUERY;
      incoming.x  = item.query_x;
    end else begin
      incoming.op = OP_LOAD;
      incoming.x  = item.point_x;
    end
  end

  assign busy      = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: sv/cli_back.sv
module cli_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cli_pkg::COUNT_W-1:0]   cfg_data,
  input  cli_pkg::queue_ctl_t           ctl_in,
  output logic                          cmd_pop,
  input  cli_pkg::cmd_t                 cmd,
  output logic                          result_valid,
  output cli_pkg::result_t              result
);
  import cli_pkg::*;

  localparam int ENTRY_W = 2 * DATA_W;
  localparam int PROD_W  = FRAC_W + 1 + DATA_W + 1;
  localparam int CNT_W   = $clog2(FRAC_W);

  logic [ENTRY_W-1:0]        mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]        rdata;
  logic [IDX_W-1:0]          raddr;
  logic                      we;

  back_state_t               state;
  back_state_t               state_next;

  logic [COUNT_W-1:0]        point_count;
  logic [IDX_W-1:0]          last_idx;

  logic signed [DATA_W-1:0]  q_x;
  logic signed [DATA_W-1:0]  x_lo;
  logic signed [DATA_W-1:0]  y_lo;
  logic signed [DATA_W-1:0]  x_hi;
  logic signed [DATA_W-1:0]  y_hi;
  logic [IDX_W-1:0]          lo;
  logic [IDX_W-1:0]          hi;
  logic [DATA_W:0]           den;
  logic [DATA_W:0]           rem;
  logic [FRAC_W-1:0]         quo;
  logic [CNT_W-1:0]          div_cnt;
  logic signed [DATA_W:0]    y_diff;
  logic signed [PROD_W-1:0]  prod;

  logic signed [DATA_W-1:0]  rd_x;
  logic signed [DATA_W-1:0]  rd_y;
  logic [IDX_W:0]            mid_sum;
  logic [IDX_W-1:0]          mid;
  logic                      search_more;
  logic signed [DATA_W:0]    num_s;
  logic signed [DATA_W:0]    den_s;
  logic                      div_skip;
  logic [DATA_W+1:0]         rem_sh;
  logic [DATA_W+1:0]         rem_sub;
  logic                      rem_ge;
  logic                      below_first;
  logic                      above_last;
  logic signed [DATA_W-1:0]  blend;

  assign rd_x        = rdata[ENTRY_W-1:DATA_W];
  assign rd_y        = rdata[DATA_W-1:0];
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid         = mid_sum[IDX_W:1];
  assign search_more = ((hi - lo) > IDX_W'(1));
  assign num_s       = {q_x[DATA_W-1], q_x} - {x_lo[DATA_W-1], x_lo};
  assign den_s       = {x_hi[DATA_W-1], x_hi} - {x_lo[DATA_W-1], x_lo};
  assign div_skip    = (den_s <= 0) || (num_s < 0);
  assign rem_sh      = {rem, 1'b0};
  assign rem_sub     = rem_sh - {1'b0, den};
  assign rem_ge      = (rem_sh >= {1'b0, den});
  assign below_first = (q_x <= rd_x);
  assign above_last  = (q_x >= rd_x);
  assign blend       = y_lo + prod[FRAC_W+DATA_W-1:FRAC_W];

  always_comb begin
    if (point_count == '0) begin
      last_idx = '0;
    end else if (point_count > COUNT_W'(TABLE_DEPTH)) begin
      last_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(point_count - 1'b1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl_in.valid && (cmd.op == OP_QUERY)) begin
          state_next = ST_CHK_FIRST;
        end
      end
      ST_CHK_FIRST: state_next = below_first ? ST_IDLE : ST_CHK_LAST;
      ST_CHK_LAST:  state_next = above_last ? ST_IDLE : ST_SEARCH;
      ST_SEARCH: begin
        if (search_more) begin
          state_next = ST_PROBE;
        end else if (div_skip) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_PROBE: state_next = ST_SEARCH;
      ST_DIV: begin
        if (div_cnt == CNT_W'(FRAC_W - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_pop = ctl_in.valid;
        we      = ctl_in.valid && (cmd.op == OP_LOAD);
      end
      ST_CHK_FIRST: raddr = last_idx;
      ST_SEARCH:    raddr = mid;
      default:      raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cmd.index] <= {cmd.x, cmd.y};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      point_count  <= POINT_COUNT_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      if (cfg_write) begin
        point_count <= cfg_data;
      end
      unique case (state)
        ST_CHK_FIRST: result_valid <= below_first;
        ST_CHK_LAST:  result_valid <= above_last;
        ST_OUT:       result_valid <= 1'b1;
        default:      result_valid <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        q_x <= cmd.x;
      end
      ST_CHK_FIRST: begin
        x_lo          <= rd_x;
        y_lo          <= rd_y;
        lo            <= '0;
        hi            <= last_idx;
        result.value  <= rd_y;
        result.region <= REGION_LOW;
      end
      ST_CHK_LAST: begin
        x_hi          <= rd_x;
        y_hi          <= rd_y;
        result.value  <= rd_y;
        result.region <= REGION_HIGH;
      end
      ST_SEARCH: begin
        den     <= den_s;
        rem     <= num_s;
        div_cnt <= '0;
        y_diff  <= {y_hi[DATA_W-1], y_hi} - {y_lo[DATA_W-1], y_lo};
        if (div_skip) begin
          quo <= '0;
        end
      end
      ST_PROBE: begin
        if (rd_x > q_x) begin
          hi   <= mid;
          x_hi <= rd_x;
          y_hi <= rd_y;
        end else begin
          lo   <= mid;
          x_lo <= rd_x;
          y_lo <= rd_y;
        end
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (rem_ge) begin
          rem <= rem_sub[DATA_W:0];
          quo <= {quo[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DATA_W:0];
          quo <= {quo[FRAC_W-2:0], 1'b0};
        end
      end
      ST_MUL: begin
        prod <= PROD_W'($signed({1'b0, quo})) * PROD_W'(y_diff);
      end
      ST_OUT: begin
        result.value  <= blend;
        result.region <= REGION_INSIDE;
      end
      default: begin
        q_x <= q_x;
      end
    endcase
  end

endmodule

// File: sv/clamped_linear_interpolator_top.sv
// Load: passes through the queue into the back end, which writes it to the table; no result.
// Query: the strobe follows the first-point check when clamped low, the last-point check when
// clamped high, and inside the range a binary search (a search and a probe state per probe on
// the one read port), a bit-serial divider and one multiply. One query is worked on at a time.
// A two-entry queue takes items while the back end works; busy rises when it is full.
// rst clears control state and sets the point count to 2; the table is undefined until loaded.
module clamped_linear_interpolator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  cli_pkg::item_t                item,
  output logic                          busy,
  output logic                          result_valid,
  output cli_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cli_pkg::COUNT_W-1:0]   cfg_data
);
  import cli_pkg::*;

  cmd_t       cmd;
  queue_ctl_t ctl;
  logic       cmd_valid;
  logic       cmd_pop;

  assign cfg_ready = 1'b1;
  assign ctl.valid = cmd_valid;
  assign ctl.pop   = cmd_pop;

  cli_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (ctl.pop)
  );

  cli_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .ctl_in       (ctl),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: dv/clamped_linear_interpolator_top_test.sv
module clamped_linear_interpolator_top_test;
  import cli_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int DRAIN     = 60;
  localparam int MAX_SHOWN = 10;

  localparam logic signed [DATA_W-1:0] MIN_Q = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_Q = 32'sh7fff_ffff;

  logic               clk;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  item_t              item         = '0;
  logic               busy;
  logic               result_valid;
  result_t            result;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data     = '0;

  logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_reg = POINT_COUNT_RESET;
  result_t                  expected_values [$];

  int errors     = 0;
  int loads      = 0;
  int queries    = 0;
  int cfg_writes = 0;
  int n_inside   = 0;
  int n_low      = 0;
  int n_high     = 0;
  int cycles     = 0;
  int burst_left = 0;
  bit steady     = 1'b0;

  clamped_linear_interpolator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               expected_values.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int points_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(count_reg);
  endfunction

  function automatic result_t interpolate_at(logic signed [DATA_W-1:0] q);
    result_t r;
    int      n, lo, hi, mid;
    longint  num, den, t, blend;
    n = points_in_use();
    if (q <= bp_x[0]) begin
      r.value  = bp_y[0];
      r.region = REGION_LOW;
      return r;
    end
    if (q >= bp_x[n-1]) begin
      r.value  = bp_y[n-1];
      r.region = REGION_HIGH;
      return r;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (bp_x[mid] > q) hi = mid;
      else lo = mid;
    end
    num = longint'(q) - longint'(bp_x[lo]);
    den = longint'(bp_x[hi]) - longint'(bp_x[lo]);
    t = (den <= 0 || num < 0) ? 0 : (num <<< FRAC_W) / den;
    if (t > 65535) t = 65535;
    blend = longint'(bp_y[lo])
          + ((t * (longint'(bp_y[hi]) - longint'(bp_y[lo]))) >>> FRAC_W);
    if (blend > longint'(MAX_Q)) blend = longint'(MAX_Q);
    if (blend < longint'(MIN_Q)) blend = longint'(MIN_Q);
    r.value  = blend[DATA_W-1:0];
    r.region = REGION_INSIDE;
    return r;
  endfunction

  function automatic void record_transfer(item_t it);
    if (it.kind == OP_LOAD) begin
      bp_x[it.point_index] = it.point_x;
      bp_y[it.point_index] = it.point_y;
      loads++;
    end else begin
      expected_values.insert(expected_values.size(), interpolate_at(it.query_x));
      queries++;
    end
  endfunction

  function automatic item_t make_load(logic [7:0] idx, logic signed [DATA_W-1:0] x,
                                      logic signed [DATA_W-1:0] y);
    item_t it;
    it.kind        = OP_LOAD;
    it.point_index = idx;
    it.point_x     = x;
    it.point_y     = y;
    it.query_x     = $urandom();
    return it;
  endfunction

  function automatic item_t make_query(logic signed [DATA_W-1:0] q);
    item_t it;
    it.kind        = OP_QUERY;
    it.point_index = 8'($urandom());
    it.point_x     = $urandom();
    it.point_y     = $urandom();
    it.query_x     = q;
    return it;
  endfunction

  function automatic longint rand_between(longint a, longint b);
    longint unsigned r;
    r = {$urandom(), $urandom()};
    if (b <= a) return a;
    return a + longint'(r % longint'(b - a + 1));
  endfunction

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic send_item(item_t it);
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do begin
      @(posedge clk);
    end while (busy);
    record_transfer(it);
  endtask

  task automatic push_item(item_t it);
    if (burst_left == 0) begin
      if (!steady)
        pause(($urandom_range(0, 3) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_item(it);
  endtask

  // drop start, drain all results, then let trailing loads retire
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    count_reg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_query();
    longint                   xa, xb;
    int                       n;
    logic signed [DATA_W-1:0] q;
    n  = points_in_use();
    xa = bp_x[0];
    xb = bp_x[n-1];
    case ($urandom_range(0, 9))
      0, 1:    q = $urandom();
      2:       q = bp_x[$urandom_range(0, n - 1)];
      3:       q = DATA_W'(($urandom_range(0, 1) == 0) ? xa + 1 : xb - 1);
      default: q = DATA_W'(rand_between(xa, xb));
    endcase
    push_item(make_query(q));
  endtask

  task automatic fill_table(int n);
    longint step, x;
    step = ((longint'(1) << 32) / (n + 1)) >>> $urandom_range(0, 20);
    if (step < 1) step = 1;
    x = rand_between(-(longint'(1) << 31), (longint'(1) << 31) - 1 - longint'(n) * step);
    for (int i = 0; i < n; i++) begin
      if (i > 0) x += rand_between(($urandom_range(0, 7) == 0) ? 0 : 1, step);
      push_item(make_load(8'(i), DATA_W'(x), $urandom()));
    end
  endtask

  task automatic test_default_count();
    push_item(make_load(8'd0, -32'sd196608, 32'sd327680));
    push_item(make_load(8'd1, 32'sd327680, -32'sd458752));
    push_item(make_query(MIN_Q));
    push_item(make_query(-32'sd196608));
    push_item(make_query(-32'sd196607));
    push_item(make_query(32'sd0));
    push_item(make_query(32'sd327679));
    push_item(make_query(32'sd327680));
    push_item(make_query(MAX_Q));
  endtask

  task automatic test_full_scale();
    push_item(make_load(8'd0, MIN_Q, MAX_Q));
    push_item(make_load(8'd1, MAX_Q, MIN_Q));
    push_item(make_query(32'sd0));
    push_item(make_query(MIN_Q + 32'sd1));
    push_item(make_query(MAX_Q - 32'sd1));
  endtask

  task automatic test_single_point();
    wait_idle();
    cfg_write(COUNT_W'(1));
    push_item(make_query(MIN_Q));
    push_item(make_query(32'sd12345));
    wait_idle();
    cfg_write(COUNT_W'(0));
    push_item(make_query(MAX_Q));
    push_item(make_query(MIN_Q));
  endtask

  task automatic test_unordered();
    wait_idle();
    cfg_write(COUNT_W'(3));
    push_item(make_load(8'd1, 32'sd655360, MIN_Q));
    push_item(make_load(8'd2, 32'sd262144, MAX_Q));
    push_item(make_query(32'sd131072));
    push_item(make_query(-32'sd1));
    push_item(make_query(32'sd262143));
    push_item(make_query(32'sd300000));
  endtask

  task automatic test_random_tables();
    int plan [8];
    int n;
    plan    = '{2, 7, 256, 511, 3, 16, 0, 0};
    plan[6] = $urandom_range(2, 32);
    plan[7] = $urandom_range(4, 64);
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      cfg_write(COUNT_W'(plan[p]));
      n      = points_in_use();
      steady = (p == 4);
      if (plan[p] <= TABLE_DEPTH) fill_table(n);
      for (int k = 0; k < ((n >= TABLE_DEPTH) ? 80 : 55); k++) begin
        if ($urandom_range(0, 11) == 0)
          push_item(make_load(8'($urandom()), $urandom(), $urandom()));
        else
          random_query();
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid) begin
      if (expected_values.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("cycle %0d: unexpected result value %h region %0d",
                   cycles, result.value, result.region);
      end else begin
        want = expected_values.pop_front();
        case (want.region)
          REGION_INSIDE: n_inside++;
          REGION_LOW:    n_low++;
          default:       n_high++;
        endcase
        if (result.value !== want.value || result.region !== want.region) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("cycle %0d: expected value %h region %0d, got value %h region %0d",
                     cycles, want.value, want.region, result.value, result.region);
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_default_count();
    test_full_scale();
    test_single_point();
    test_unordered();
    test_random_tables();
    @(negedge clk);
    start <= 1'b0;
    for (int w = 0; w < 2000 && expected_values.size() != 0; w++) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (expected_values.size() != 0) begin
      $display("%0d results never arrived", expected_values.size());
      errors += expected_values.size();
    end
    $display("sent %0d breakpoint loads and %0d queries over %0d point-count settings",
             loads, queries, cfg_writes);
    $display("results: %0d interpolated, %0d clamped low, %0d clamped high; %0d errors",
             n_inside, n_low, n_high, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
